// ===== sv/json_token_stream_checker_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the JSON token stream checker
// Each macro checks one property on the rising edge of clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef JSON_TOKEN_STREAM_CHECKER_ASSERT_SVH
`define JSON_TOKEN_STREAM_CHECKER_ASSERT_SVH

// same-cycle implication
`define JTSC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define JTSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/jtsc_pkg.sv =====
// ---------------------------------------------------------------------------
// jtsc_pkg
// Shared constants, codes, byte classes and the queue item type.
// ---------------------------------------------------------------------------
`default_nettype none

package jtsc_pkg;

	localparam int MAX_DEPTH = 32;
	localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
	localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int NEST_W    = 6;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W     = $clog2(FIFO_DEPTH);
	localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);

	// characters
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam logic [39:0] WORD_TRUE  = 40'h0074727565;
	localparam logic [39:0] WORD_FALSE = 40'h66616C7365;
	localparam logic [39:0] WORD_NULL  = 40'h006E756C6C;

	// byte classes
	localparam logic [3:0] C_WS     = 4'd0;
	localparam logic [3:0] C_OBEG   = 4'd1;
	localparam logic [3:0] C_OEND   = 4'd2;
	localparam logic [3:0] C_COLON  = 4'd3;
	localparam logic [3:0] C_ABEG   = 4'd4;
	localparam logic [3:0] C_AEND   = 4'd5;
	localparam logic [3:0] C_COMMA  = 4'd6;
	localparam logic [3:0] C_QUOTE  = 4'd7;
	localparam logic [3:0] C_BSLASH = 4'd8;
	localparam logic [3:0] C_DIGIT  = 4'd9;
	localparam logic [3:0] C_MINUS  = 4'd10;
	localparam logic [3:0] C_PLUS   = 4'd11;
	localparam logic [3:0] C_DOT    = 4'd12;
	localparam logic [3:0] C_EXP    = 4'd13;
	localparam logic [3:0] C_ALPHA  = 4'd14;
	localparam logic [3:0] C_OTHER  = 4'd15;

	// token kinds
	localparam logic [3:0] K_NONE  = 4'd0;
	localparam logic [3:0] K_OBEG  = 4'd1;
	localparam logic [3:0] K_OEND  = 4'd2;
	localparam logic [3:0] K_COLON = 4'd3;
	localparam logic [3:0] K_STR   = 4'd4;
	localparam logic [3:0] K_NUM   = 4'd5;
	localparam logic [3:0] K_ABEG  = 4'd6;
	localparam logic [3:0] K_AEND  = 4'd7;
	localparam logic [3:0] K_COMMA = 4'd8;
	localparam logic [3:0] K_BOOL  = 4'd9;
	localparam logic [3:0] K_NULL  = 4'd10;
	localparam logic [3:0] K_WORD  = 4'd11;

	// status codes
	localparam logic [2:0] S_OK     = 3'd0;
	localparam logic [2:0] S_DONE   = 3'd1;
	localparam logic [2:0] S_TOKEN  = 3'd2;
	localparam logic [2:0] S_NUMBER = 3'd3;
	localparam logic [2:0] S_WORD   = 3'd4;
	localparam logic [2:0] S_EARLY  = 3'd5;
	localparam logic [2:0] S_DEEP   = 3'd6;
	localparam logic [2:0] S_CHAR   = 3'd7;

	// lexer modes
	localparam logic [3:0] M_IDLE   = 4'd0;
	localparam logic [3:0] M_STR    = 4'd1;
	localparam logic [3:0] M_ESC    = 4'd2;
	localparam logic [3:0] M_NSIGN  = 4'd3;
	localparam logic [3:0] M_NINT   = 4'd4;
	localparam logic [3:0] M_NDOT   = 4'd5;
	localparam logic [3:0] M_NFRAC  = 4'd6;
	localparam logic [3:0] M_NE     = 4'd7;
	localparam logic [3:0] M_NESIGN = 4'd8;
	localparam logic [3:0] M_NEXP   = 4'd9;
	localparam logic [3:0] M_WORD   = 4'd10;
	localparam logic [3:0] NUM_BAD  = 4'd14;
	localparam logic [3:0] NUM_END  = 4'd15;

	// grammar expectations
	localparam logic [2:0] G_START = 3'd0;
	localparam logic [2:0] G_KEY   = 3'd1;
	localparam logic [2:0] G_COLON = 3'd2;
	localparam logic [2:0] G_VALUE = 3'd3;
	localparam logic [2:0] G_NEXT  = 3'd4;
	localparam logic [2:0] G_ARR   = 3'd5;
	localparam logic [2:0] G_DONE  = 3'd6;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_END  = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] text_byte;
		logic [3:0] cls;
	} item_t;

	function automatic logic [3:0] classify(input logic [7:0] b);
		logic [3:0] c;
		case (b) inside
			CH_SPACE, [8'h09:8'h0D]: c = C_WS;
			CH_LBRACE:               c = C_OBEG;
			CH_RBRACE:               c = C_OEND;
			CH_COLON:                c = C_COLON;
			CH_LBRACK:               c = C_ABEG;
			CH_RBRACK:               c = C_AEND;
			CH_COMMA:                c = C_COMMA;
			CH_QUOTE:                c = C_QUOTE;
			CH_BSLASH:               c = C_BSLASH;
			[8'h30:8'h39]:           c = C_DIGIT;
			CH_MINUS:                c = C_MINUS;
			CH_PLUS:                 c = C_PLUS;
			CH_DOT:                  c = C_DOT;
			8'h65, 8'h45:            c = C_EXP;
			[8'h61:8'h7A], [8'h41:8'h5A]: c = C_ALPHA;
			default:                 c = C_OTHER;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== sv/json_token_stream_checker.sv =====
// ---------------------------------------------------------------------------
// json_token_stream_checker
// Streaming JSON tokenizer and object/array grammar checker, one byte a beat.
// ---------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | op, text_byte
//  out     | out_valid / out_ready| token_kind, char_out, is_content, token_start,
//          |                      | token_done, prior_done, prior_kind, bool_value,
//          |                      | is_key, nest_level, status
//
//  One beat in gives one beat out; both sides sustain one beat per cycle while
//  out_ready stays high. Each beat passes through the 4-entry classify queue,
//  then the lexer/grammar update into the output register.
//  The state update (lexer mode, grammar, nesting stack) sets the rate.
//  Reset clears all control state at once; no clearing pass is needed.
//  A stalled output holds its beat; the queue keeps taking input until full.
// ---------------------------------------------------------------------------
`default_nettype none

module json_token_stream_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output      logic                        in_ready,
	input  wire logic                        op,
	input  wire logic [7:0]                  text_byte,
	output      logic                        out_valid,
	input  wire logic                        out_ready,
	output      logic [3:0]                  token_kind,
	output      logic [7:0]                  char_out,
	output      logic                        is_content,
	output      logic                        token_start,
	output      logic                        token_done,
	output      logic                        prior_done,
	output      logic [3:0]                  prior_kind,
	output      logic                        bool_value,
	output      logic                        is_key,
	output      logic [jtsc_pkg::NEST_W-1:0] nest_level,
	output      logic [2:0]                  status
);
	import jtsc_pkg::*;

	logic  q_valid;
	item_t q_item;
	logic  q_pop;

	jtsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.text_byte (text_byte),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	jtsc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.token_kind  (token_kind),
		.char_out    (char_out),
		.is_content  (is_content),
		.token_start (token_start),
		.token_done  (token_done),
		.prior_done  (prior_done),
		.prior_kind  (prior_kind),
		.bool_value  (bool_value),
		.is_key      (is_key),
		.nest_level  (nest_level),
		.status      (status)
	);

endmodule

`default_nettype wire

// ===== sv/jtsc_front.sv =====
// ---------------------------------------------------------------------------
// jtsc_front
// Accepts input beats, classifies each byte and queues it for the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module jtsc_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output      logic              in_ready,
	input  wire logic              op,
	input  wire logic [7:0]        text_byte,
	output      logic              q_valid,
	output      jtsc_pkg::item_t   q_item,
	input  wire logic              q_pop
);
	import jtsc_pkg::*;

	item_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	item_t             new_item;
	logic              push;
	logic              pop;

	assign in_ready = (count_q != CNT_W'(FIFO_DEPTH));
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && q_valid;
	assign q_valid  = (count_q != '0);
	assign q_item   = mem_q[rd_ptr_q];

	// end of input carries a zero byte
	always_comb begin
		new_item.op        = op;
		new_item.text_byte = (op == OP_END) ? 8'h00 : text_byte;
		new_item.cls       = (op == OP_END) ? C_OTHER : classify(text_byte);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/jtsc_back.sv =====
// ---------------------------------------------------------------------------
// jtsc_back
// Lexer and grammar state; turns each queued byte into one result beat.
// ---------------------------------------------------------------------------
`default_nettype none

`include "json_token_stream_checker_assert.svh"

module jtsc_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_valid,
	input  wire jtsc_pkg::item_t     q_item,
	output      logic                q_pop,
	output      logic                out_valid,
	input  wire logic                out_ready,
	output      logic [3:0]          token_kind,
	output      logic [7:0]          char_out,
	output      logic                is_content,
	output      logic                token_start,
	output      logic                token_done,
	output      logic                prior_done,
	output      logic [3:0]          prior_kind,
	output      logic                bool_value,
	output      logic                is_key,
	output      logic [jtsc_pkg::NEST_W-1:0] nest_level,
	output      logic [2:0]          status
);
	import jtsc_pkg::*;

	// architectural state
	logic [3:0]          mode_q;
	logic [2:0]          gexp_q;
	logic [MAX_DEPTH-1:0] stack_q;
	logic [DEPTH_W-1:0]  depth_q;
	logic [39:0]         wbuf_q;
	logic [2:0]          wlen_q;
	logic [2:0]          status_q;

	// output register
	logic                out_valid_q;
	logic [3:0]          kind_q;
	logic [7:0]          char_q;
	logic                content_q;
	logic                start_q;
	logic                done_q;
	logic                pdone_q;
	logic [3:0]          pkind_q;
	logic                bval_q;
	logic                key_q;
	logic [DEPTH_W-1:0]  nest_q;

	logic                op_b;
	logic [7:0]          c_b;
	logic [3:0]          cls_b;

	logic                arr;
	logic [DEPTH_W-1:0]  depth_m1;
	logic [3:0]          tok_k;
	logic [3:0]          gk;
	logic [2:0]          g_err;
	logic [2:0]          g_gexp;
	logic [DEPTH_W-1:0]  g_depth;
	logic                g_push;
	logic                value_slot;
	logic                is_dig;
	logic                is_exp;
	logic [3:0]          num_nx;

	logic [3:0]          n_mode;
	logic [2:0]          n_gexp;
	logic [DEPTH_W-1:0]  n_depth;
	logic [39:0]         n_wbuf;
	logic [2:0]          n_wlen;
	logic [2:0]          n_status;
	logic                push_en;
	logic                pending;
	logic [2:0]          err;
	logic [3:0]          r_kind;
	logic                r_content;
	logic                r_start;
	logic                r_done;
	logic                r_pdone;
	logic [3:0]          r_pkind;
	logic                r_bval;
	logic                r_key;

	assign op_b  = q_item.op;
	assign c_b   = q_item.text_byte;
	assign cls_b = q_item.cls;

	assign q_pop = q_valid && (!out_valid_q || out_ready);

	assign depth_m1   = depth_q - 1'b1;
	assign arr        = (depth_q != '0) && stack_q[depth_m1[IDX_W-1:0]];
	assign value_slot = (gexp_q == G_VALUE) || (gexp_q == G_ARR);
	assign is_dig     = (cls_b == C_DIGIT);
	assign is_exp     = (cls_b == C_EXP);

	// token kind of a byte between tokens
	always_comb begin
		case (cls_b)
			C_OBEG:           tok_k = K_OBEG;
			C_OEND:           tok_k = K_OEND;
			C_COLON:          tok_k = K_COLON;
			C_ABEG:           tok_k = K_ABEG;
			C_AEND:           tok_k = K_AEND;
			C_COMMA:          tok_k = K_COMMA;
			C_QUOTE:          tok_k = K_STR;
			C_DIGIT, C_MINUS: tok_k = K_NUM;
			C_ALPHA, C_EXP:   tok_k = K_WORD;
			default:          tok_k = K_NONE;
		endcase
	end

	// grammar check of a token that starts with this byte; a word checks as a value
	assign gk = (tok_k == K_WORD) ? K_NULL : tok_k;

	always_comb begin
		g_err   = S_OK;
		g_gexp  = gexp_q;
		g_depth = depth_q;
		g_push  = 1'b0;
		case (gk)
			K_OBEG, K_ABEG: begin
				if (!(value_slot || (gexp_q == G_START && gk == K_OBEG))) begin
					g_err = S_TOKEN;
				end else if (depth_q >= DEPTH_W'(MAX_DEPTH)) begin
					g_err = S_DEEP;
				end else begin
					g_push  = 1'b1;
					g_depth = depth_q + 1'b1;
					g_gexp  = (gk == K_ABEG) ? G_ARR : G_KEY;
				end
			end
			K_OEND, K_AEND: begin
				if (depth_q == '0) begin
					g_err = S_TOKEN;
				end else if (gk == K_OEND &&
						!(gexp_q == G_KEY || (gexp_q == G_NEXT && !arr))) begin
					g_err = S_TOKEN;
				end else if (gk == K_AEND &&
						!(gexp_q == G_ARR || (gexp_q == G_NEXT && arr))) begin
					g_err = S_TOKEN;
				end else begin
					g_depth = depth_m1;
					if (depth_m1 == '0) begin
						g_gexp = G_DONE;
						g_err  = S_DONE;
					end else begin
						g_gexp = G_NEXT;
					end
				end
			end
			K_COLON: begin
				if (gexp_q != G_COLON) begin
					g_err = S_TOKEN;
				end else begin
					g_gexp = G_VALUE;
				end
			end
			K_COMMA: begin
				if (gexp_q != G_NEXT) begin
					g_err = S_TOKEN;
				end else begin
					g_gexp = arr ? G_ARR : G_KEY;
				end
			end
			default: begin
				if (gk == K_STR && gexp_q == G_KEY) begin
					g_gexp = G_COLON;
				end else if (!value_slot) begin
					g_err = S_TOKEN;
				end else begin
					g_gexp = G_NEXT;
				end
			end
		endcase
	end

	// number lexer step
	always_comb begin
		case (mode_q)
			M_NSIGN: num_nx = is_dig ? M_NINT : NUM_BAD;
			M_NINT: begin
				if (is_dig) begin
					num_nx = M_NINT;
				end else if (cls_b == C_DOT) begin
					num_nx = M_NDOT;
				end else begin
					num_nx = is_exp ? M_NE : NUM_END;
				end
			end
			M_NDOT: num_nx = is_dig ? M_NFRAC : NUM_BAD;
			M_NFRAC: begin
				if (is_dig) begin
					num_nx = M_NFRAC;
				end else begin
					num_nx = is_exp ? M_NE : NUM_END;
				end
			end
			M_NE: begin
				if (cls_b == C_PLUS || cls_b == C_MINUS) begin
					num_nx = M_NESIGN;
				end else begin
					num_nx = is_dig ? M_NEXP : NUM_BAD;
				end
			end
			M_NESIGN: num_nx = is_dig ? M_NEXP : NUM_BAD;
			default:  num_nx = is_dig ? M_NEXP : NUM_END;
		endcase
	end

	// lexer and result
	always_comb begin
		n_mode    = mode_q;
		n_gexp    = gexp_q;
		n_depth   = depth_q;
		n_wbuf    = wbuf_q;
		n_wlen    = wlen_q;
		n_status  = status_q;
		push_en   = 1'b0;
		pending   = 1'b1;
		err       = S_OK;
		r_kind    = K_NONE;
		r_content = 1'b0;
		r_start   = 1'b0;
		r_done    = 1'b0;
		r_pdone   = 1'b0;
		r_pkind   = K_NONE;
		r_bval    = 1'b0;
		r_key     = 1'b0;

		if (status_q == S_OK) begin
			if (mode_q == M_STR || mode_q == M_ESC) begin
				pending = 1'b0;
				if (op_b == OP_END) begin
					err = S_EARLY;
				end else begin
					r_kind = K_STR;
					r_key  = (gexp_q == G_COLON);
					if (mode_q == M_ESC) begin
						r_content = 1'b1;
						n_mode    = M_STR;
					end else if (cls_b == C_QUOTE) begin
						r_done = 1'b1;
						n_mode = M_IDLE;
					end else begin
						r_content = 1'b1;
						if (cls_b == C_BSLASH) begin
							n_mode = M_ESC;
						end
					end
				end
			end else if (mode_q >= M_NSIGN && mode_q <= M_NEXP) begin
				if (num_nx == NUM_BAD) begin
					err = S_NUMBER;
				end else if (num_nx == NUM_END) begin
					r_pdone = 1'b1;
					r_pkind = K_NUM;
					n_mode  = M_IDLE;
				end else begin
					n_mode    = num_nx;
					r_kind    = K_NUM;
					r_content = 1'b1;
					pending   = 1'b0;
				end
			end else if (mode_q == M_WORD) begin
				if (cls_b == C_ALPHA || cls_b == C_EXP) begin
					if (wlen_q >= 3'd5) begin
						err = S_WORD;
					end else begin
						n_wbuf    = {wbuf_q[31:0], c_b};
						n_wlen    = wlen_q + 1'b1;
						r_kind    = K_WORD;
						r_content = 1'b1;
						pending   = 1'b0;
					end
				end else begin
					// close the word and match it
					n_wbuf = '0;
					n_wlen = '0;
					n_mode = M_IDLE;
					if (wlen_q == 3'd4 && wbuf_q == WORD_TRUE) begin
						r_pdone = 1'b1;
						r_pkind = K_BOOL;
						r_bval  = 1'b1;
					end else if (wlen_q == 3'd5 && wbuf_q == WORD_FALSE) begin
						r_pdone = 1'b1;
						r_pkind = K_BOOL;
					end else if (wlen_q == 3'd4 && wbuf_q == WORD_NULL) begin
						r_pdone = 1'b1;
						r_pkind = K_NULL;
					end else begin
						err = S_WORD;
					end
				end
			end

			if (err == S_OK && op_b == OP_END) begin
				err = S_EARLY;
			end else if (err == S_OK && pending && cls_b != C_WS) begin
				if (tok_k == K_NONE) begin
					err = S_CHAR;
				end else begin
					err = g_err;
					if (g_err == S_OK || g_err == S_DONE) begin
						n_gexp  = g_gexp;
						n_depth = g_depth;
						push_en = g_push;
						r_kind  = tok_k;
						r_start = 1'b1;
						case (tok_k)
							K_STR: begin
								n_mode = M_STR;
								r_key  = (g_gexp == G_COLON);
							end
							K_NUM: begin
								n_mode    = (cls_b == C_MINUS) ? M_NSIGN : M_NINT;
								r_content = 1'b1;
							end
							K_WORD: begin
								n_mode    = M_WORD;
								n_wbuf    = {32'h0, c_b};
								n_wlen    = 3'd1;
								r_content = 1'b1;
							end
							default: r_done = 1'b1;
						endcase
					end
				end
			end

			// an error beat reports only a well-ended prior token
			if (err != S_OK && err != S_DONE) begin
				r_kind    = K_NONE;
				r_content = 1'b0;
				r_start   = 1'b0;
				r_done    = 1'b0;
				r_key     = 1'b0;
			end
			n_status = err;
		end
	end

	// stack entries hold no reset: only pushed entries are ever read
	always_ff @(posedge clk) begin
		if (q_pop && push_en) begin
			stack_q[depth_q[IDX_W-1:0]] <= (tok_k == K_ABEG);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= M_IDLE;
			gexp_q      <= G_START;
			depth_q     <= '0;
			wbuf_q      <= '0;
			wlen_q      <= '0;
			status_q    <= S_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				mode_q      <= n_mode;
				gexp_q      <= n_gexp;
				depth_q     <= n_depth;
				wbuf_q      <= n_wbuf;
				wlen_q      <= n_wlen;
				status_q    <= n_status;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_q    <= r_kind;
			char_q    <= c_b;
			content_q <= r_content;
			start_q   <= r_start;
			done_q    <= r_done;
			pdone_q   <= r_pdone;
			pkind_q   <= r_pkind;
			bval_q    <= r_bval;
			key_q     <= r_key;
			nest_q    <= n_depth;
		end
	end

	assign out_valid   = out_valid_q;
	assign token_kind  = kind_q;
	assign char_out    = char_q;
	assign is_content  = content_q;
	assign token_start = start_q;
	assign token_done  = done_q;
	assign prior_done  = pdone_q;
	assign prior_kind  = pkind_q;
	assign bool_value  = bval_q;
	assign is_key      = key_q;
	assign nest_level  = NEST_W'(nest_q);
	assign status      = status_q;

	`JTSC_ASSERT_NEXT(a_status_sticky, status_q != S_OK, $stable(status_q), "status left a final state")
	`JTSC_ASSERT_NOW(a_depth_bound, 1'b1, depth_q <= DEPTH_W'(MAX_DEPTH), "nesting depth out of range")
	`JTSC_ASSERT_NOW(a_done_status, gexp_q == G_DONE, status_q == S_DONE, "grammar done without done status")
	`JTSC_ASSERT_NOW(a_empty_start, depth_q == '0 && status_q == S_OK, gexp_q == G_START && mode_q == M_IDLE, "empty stack while parsing")

endmodule

`default_nettype wire

// ===== bench/json_token_stream_checker_tb.sv =====
// ---------------------------------------------------------------------------
// json_token_stream_checker_tb
// Drives one JSON document, a byte a beat, through the checker and compares
// every result beat field by field with a local tokenizer and grammar model.
// The document opens with a fixed table of bytes. A long run of random
// well-formed members follows, with one deep chain of arrays. It ends in a
// randomly chosen way (clean close or one of the error kinds), followed by
// bytes that the block must ignore. Both sides stall at random.
// ---------------------------------------------------------------------------

module json_token_stream_checker_tb;

	import jtsc_pkg::*;

	localparam int OPENING_LEN  = 26;
	localparam int BODY_BYTES   = 1600;
	localparam int NOISE_BEATS  = 24;
	localparam int IDLE_PCT     = 6;
	localparam int QUIET_FROM   = 600;
	localparam int QUIET_TO     = 1000;
	localparam int PAUSE_AT     = 1200;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 100000;

	typedef struct packed {
		logic [3:0]        kind;
		logic [7:0]        ch;
		logic              content;
		logic              start;
		logic              done;
		logic              pdone;
		logic [3:0]        pkind;
		logic              bval;
		logic              key;
		logic [NEST_W-1:0] nest;
		logic [2:0]        status;
	} tok_t;

	typedef struct packed {
		logic       op;
		logic [7:0] ch;
		logic       typed;
		tok_t       want;
	} feed_t;

	// how the document ends
	typedef enum int {
		FIN_CLOSE,
		FIN_BAD_TOKEN,
		FIN_BAD_CHAR,
		FIN_BAD_NUMBER,
		FIN_BAD_WORD,
		FIN_EARLY,
		FIN_TOO_DEEP
	} ending_e;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              op = OP_BYTE;
	logic [7:0]        text_byte = 8'h00;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [3:0]        token_kind;
	logic [7:0]        char_out;
	logic              is_content;
	logic              token_start;
	logic              token_done;
	logic              prior_done;
	logic [3:0]        prior_kind;
	logic              bool_value;
	logic              is_key;
	logic [NEST_W-1:0] nest_level;
	logic [2:0]        status;

	json_token_stream_checker dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// model state, starting from its reset values
	logic [3:0]  lex_mode = M_IDLE;
	logic [2:0]  gram_state = G_START;
	logic        nest_is_array [MAX_DEPTH];
	int          open_depth = 0;
	logic [39:0] word_bits = '0;
	int          word_len = 0;
	logic [2:0]  sticky = S_OK;

	feed_t       byte_feed [$];
	tok_t        awaited_tokens [$];
	int          bytes_sent = 0;
	int          field_mismatches = 0;
	bit          pause_done = 1'b0;
	int unsigned cycle_count = 0;

	logic [7:0] blanks [6] = '{8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, CH_SPACE};

	// space, {, key with escaped quote and 0xFF, :, -0.9E+7, empty key,
	// array holding true and a trailing comma
	logic [7:0] opening_text [OPENING_LEN] = '{
		CH_SPACE, CH_LBRACE, CH_QUOTE, CH_BSLASH, CH_QUOTE, 8'hFF, CH_QUOTE, CH_COLON,
		CH_MINUS, "0", CH_DOT, "9", "E", CH_PLUS, "7", CH_COMMA,
		CH_QUOTE, CH_QUOTE, CH_COLON, CH_LBRACK, "t", "r", "u", "e", CH_COMMA, CH_RBRACK
	};
	int   typed_rows [4] = '{0, 1, 2, 24};
	tok_t typed_want [4];

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	// check a token at its start and move the grammar; returns a status
	function automatic logic [2:0] grammar_advance(input logic [3:0] kind);
		logic [2:0] g;
		logic       arr;
		logic       value_slot;
		g = gram_state;
		arr = (open_depth == 0) ? 1'b0 : nest_is_array[open_depth - 1];
		value_slot = (g == G_VALUE) || (g == G_ARR);
		case (kind)
			K_OBEG, K_ABEG: begin
				if (!(value_slot || (g == G_START && kind == K_OBEG)))
					return S_TOKEN;
				if (open_depth >= MAX_DEPTH)
					return S_DEEP;
				nest_is_array[open_depth] = (kind == K_ABEG);
				open_depth++;
				gram_state = (kind == K_ABEG) ? G_ARR : G_KEY;
				return S_OK;
			end
			K_OEND, K_AEND: begin
				if (open_depth == 0)
					return S_TOKEN;
				if (kind == K_OEND && !(g == G_KEY || (g == G_NEXT && !arr)))
					return S_TOKEN;
				if (kind == K_AEND && !(g == G_ARR || (g == G_NEXT && arr)))
					return S_TOKEN;
				open_depth--;
				if (open_depth == 0) begin
					gram_state = G_DONE;
					return S_DONE;
				end
				gram_state = G_NEXT;
				return S_OK;
			end
			K_COLON: begin
				if (g != G_COLON)
					return S_TOKEN;
				gram_state = G_VALUE;
				return S_OK;
			end
			K_COMMA: begin
				if (g != G_NEXT)
					return S_TOKEN;
				gram_state = arr ? G_ARR : G_KEY;
				return S_OK;
			end
			default: begin
				if (kind == K_STR && g == G_KEY) begin
					gram_state = G_COLON;
					return S_OK;
				end
				if (!value_slot)
					return S_TOKEN;
				gram_state = G_NEXT;
				return S_OK;
			end
		endcase
	endfunction

	function automatic logic [3:0] number_step(input logic [7:0] c);
		logic d;
		logic e;
		d = is_digit(c);
		e = (c == "e") || (c == "E");
		case (lex_mode)
			M_NSIGN: return d ? M_NINT : NUM_BAD;
			M_NINT: begin
				if (d)
					return M_NINT;
				if (c == CH_DOT)
					return M_NDOT;
				return e ? M_NE : NUM_END;
			end
			M_NDOT: return d ? M_NFRAC : NUM_BAD;
			M_NFRAC: begin
				if (d)
					return M_NFRAC;
				return e ? M_NE : NUM_END;
			end
			M_NE: begin
				if (c == CH_PLUS || c == CH_MINUS)
					return M_NESIGN;
				return d ? M_NEXP : NUM_BAD;
			end
			M_NESIGN: return d ? M_NEXP : NUM_BAD;
			default: return d ? M_NEXP : NUM_END;
		endcase
	endfunction

	// expected result beat for one accepted input beat
	function automatic tok_t tokenize_byte(input logic op_in, input logic [7:0] b_in);
		tok_t       t;
		logic [7:0] c;
		logic [2:0] err;
		logic [3:0] nx;
		logic [3:0] k;
		logic       pending;
		t = '0;
		c = (op_in == OP_END) ? 8'h00 : b_in;
		t.ch = c;
		if (sticky == S_OK) begin
			err = S_OK;
			pending = 1'b1;
			if (lex_mode == M_STR || lex_mode == M_ESC) begin
				pending = 1'b0;
				if (op_in == OP_END) begin
					err = S_EARLY;
				end else begin
					t.kind = K_STR;
					t.key = (gram_state == G_COLON);
					if (lex_mode == M_ESC) begin
						t.content = 1'b1;
						lex_mode = M_STR;
					end else if (c == CH_QUOTE) begin
						t.done = 1'b1;
						lex_mode = M_IDLE;
					end else begin
						t.content = 1'b1;
						if (c == CH_BSLASH)
							lex_mode = M_ESC;
					end
				end
			end else if (lex_mode >= M_NSIGN && lex_mode <= M_NEXP) begin
				nx = number_step(c);
				if (nx == NUM_BAD) begin
					err = S_NUMBER;
				end else if (nx == NUM_END) begin
					t.pdone = 1'b1;
					t.pkind = K_NUM;
					lex_mode = M_IDLE;
				end else begin
					lex_mode = nx;
					t.kind = K_NUM;
					t.content = 1'b1;
					pending = 1'b0;
				end
			end else if (lex_mode == M_WORD) begin
				if (is_letter(c)) begin
					if (word_len >= 5) begin
						err = S_WORD;
					end else begin
						word_bits = {word_bits[31:0], c};
						word_len++;
						t.kind = K_WORD;
						t.content = 1'b1;
						pending = 1'b0;
					end
				end else begin
					if (word_len == 4 && word_bits == WORD_TRUE) begin
						t.pkind = K_BOOL;
						t.bval = 1'b1;
					end else if (word_len == 5 && word_bits == WORD_FALSE) begin
						t.pkind = K_BOOL;
					end else if (word_len == 4 && word_bits == WORD_NULL) begin
						t.pkind = K_NULL;
					end else begin
						err = S_WORD;
					end
					t.pdone = (err == S_OK);
					word_bits = '0;
					word_len = 0;
					lex_mode = M_IDLE;
				end
			end

			if (err == S_OK && op_in == OP_END) begin
				err = S_EARLY;
			end else if (err == S_OK && pending && !is_blank(c)) begin
				case (c)
					CH_LBRACE: k = K_OBEG;
					CH_RBRACE: k = K_OEND;
					CH_COLON:  k = K_COLON;
					CH_LBRACK: k = K_ABEG;
					CH_RBRACK: k = K_AEND;
					CH_COMMA:  k = K_COMMA;
					CH_QUOTE:  k = K_STR;
					CH_MINUS:  k = K_NUM;
					default:   k = is_digit(c) ? K_NUM : (is_letter(c) ? K_WORD : K_NONE);
				endcase
				if (k == K_NONE) begin
					err = S_CHAR;
				end else begin
					// any word takes a value slot, like null
					err = grammar_advance((k == K_WORD) ? K_NULL : k);
					if (err == S_OK || err == S_DONE) begin
						t.kind = k;
						t.start = 1'b1;
						if (k == K_STR) begin
							lex_mode = M_STR;
							t.key = (gram_state == G_COLON);
						end else if (k == K_NUM) begin
							lex_mode = (c == CH_MINUS) ? M_NSIGN : M_NINT;
							t.content = 1'b1;
						end else if (k == K_WORD) begin
							lex_mode = M_WORD;
							word_bits = {32'h0, c};
							word_len = 1;
							t.content = 1'b1;
						end else begin
							t.done = 1'b1;
						end
					end
				end
			end
			sticky = err;
		end
		t.nest = NEST_W'(open_depth);
		t.status = sticky;
		return t;
	endfunction

	function automatic void compare_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			field_mismatches++;
		end
	endfunction

	task automatic push_beat(input logic op_v, input logic [7:0] ch);
		feed_t f;
		f = '0;
		f.op = op_v;
		f.ch = ch;
		byte_feed.insert(byte_feed.size(), f);
	endtask

	task automatic push_byte(input logic [7:0] ch);
		push_beat(OP_BYTE, ch);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	task automatic emit_gap();
		if ($urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 2)) push_byte(blanks[$urandom_range(0, 5)]);
	endtask

	task automatic emit_digits(input int lo, input int hi);
		repeat ($urandom_range(lo, hi)) push_byte(8'h30 + 8'($urandom_range(0, 9)));
	endtask

	// quoted string; quote and backslash inside are escaped, other bytes sometimes
	task automatic emit_text();
		logic [7:0] b;
		push_byte(CH_QUOTE);
		repeat ($urandom_range(0, 6)) begin
			b = 8'($urandom_range(0, 255));
			if (b == CH_QUOTE || b == CH_BSLASH || $urandom_range(0, 7) == 0)
				push_byte(CH_BSLASH);
			push_byte(b);
		end
		push_byte(CH_QUOTE);
	endtask

	task automatic emit_number();
		if ($urandom_range(0, 3) == 0)
			push_byte(CH_MINUS);
		emit_digits(1, 3);
		if ($urandom_range(0, 2) == 0) begin
			push_byte(CH_DOT);
			emit_digits(1, 2);
		end
		if ($urandom_range(0, 2) == 0) begin
			push_byte($urandom_range(0, 1) ? "e" : "E");
			case ($urandom_range(0, 2))
				0: push_byte(CH_PLUS);
				1: push_byte(CH_MINUS);
				default: ;
			endcase
			emit_digits(1, 2);
		end
	endtask

	// lvl is the number of containers open around the value
	task automatic emit_value(input int lvl);
		int n;
		case ($urandom_range(0, 9))
			0, 1: emit_text();
			2, 3: emit_number();
			4, 5: begin
				case ($urandom_range(0, 2))
					0: push_text("true");
					1: push_text("false");
					default: push_text("null");
				endcase
			end
			6, 7: begin
				if (lvl >= 5) begin
					emit_number();
				end else begin
					push_byte(CH_LBRACK);
					emit_gap();
					n = $urandom_range(0, 3);
					for (int i = 0; i < n; i++) begin
						if (i > 0)
							push_byte(CH_COMMA);
						emit_gap();
						emit_value(lvl + 1);
						emit_gap();
					end
					if (n > 0 && $urandom_range(0, 3) == 0)
						push_byte(CH_COMMA);
					push_byte(CH_RBRACK);
				end
			end
			default: begin
				if (lvl >= 5) begin
					emit_text();
				end else begin
					push_byte(CH_LBRACE);
					emit_gap();
					n = $urandom_range(0, 3);
					for (int i = 0; i < n; i++) begin
						if (i > 0)
							push_byte(CH_COMMA);
						emit_gap();
						emit_member(lvl + 1);
					end
					if (n > 0 && $urandom_range(0, 3) == 0)
						push_byte(CH_COMMA);
					push_byte(CH_RBRACE);
				end
			end
		endcase
	endtask

	task automatic emit_member(input int lvl);
		emit_text();
		emit_gap();
		push_byte(CH_COLON);
		emit_gap();
		emit_value(lvl);
		emit_gap();
	endtask

	initial begin
		ending_e ending;
		bit      deep_done;

		typed_want[0] = '{K_NONE, CH_SPACE, 1'b0, 1'b0, 1'b0, 1'b0, K_NONE, 1'b0, 1'b0,
			6'd0, S_OK};
		typed_want[1] = '{K_OBEG, CH_LBRACE, 1'b0, 1'b1, 1'b1, 1'b0, K_NONE, 1'b0, 1'b0,
			6'd1, S_OK};
		typed_want[2] = '{K_STR, CH_QUOTE, 1'b0, 1'b1, 1'b0, 1'b0, K_NONE, 1'b0, 1'b1,
			6'd1, S_OK};
		typed_want[3] = '{K_COMMA, CH_COMMA, 1'b0, 1'b1, 1'b1, 1'b1, K_BOOL, 1'b1, 1'b0,
			6'd2, S_OK};

		for (int i = 0; i < OPENING_LEN; i++) begin
			push_byte(opening_text[i]);
			foreach (typed_rows[j])
				if (typed_rows[j] == i) begin
					byte_feed[i].typed = 1'b1;
					byte_feed[i].want = typed_want[j];
				end
		end

		// top object members; one of them is a chain of arrays to full depth
		deep_done = 1'b0;
		while (byte_feed.size() < OPENING_LEN + BODY_BYTES) begin
			push_byte(CH_COMMA);
			emit_gap();
			if (!deep_done && byte_feed.size() >= 800) begin
				emit_text();
				push_byte(CH_COLON);
				repeat (MAX_DEPTH - 1) push_byte(CH_LBRACK);
				emit_value(MAX_DEPTH);
				repeat (MAX_DEPTH - 1) push_byte(CH_RBRACK);
				deep_done = 1'b1;
			end else begin
				emit_member(1);
			end
		end

		ending = ending_e'($urandom_range(0, 6));
		if (ending >= FIN_BAD_NUMBER) begin
			push_byte(CH_COMMA);
			emit_text();
			push_byte(CH_COLON);
		end
		case (ending)
			FIN_CLOSE: begin
				emit_gap();
				push_byte(CH_RBRACE);
			end
			FIN_BAD_TOKEN: push_byte(CH_COLON);
			FIN_BAD_CHAR: begin
				push_byte(CH_SPACE);
				case ($urandom_range(0, 4))
					0: push_text("#");
					1: push_byte(CH_PLUS);
					2: push_byte(CH_DOT);
					3: push_byte(8'h00);
					default: push_byte(8'h80 + 8'($urandom_range(0, 127)));
				endcase
			end
			FIN_BAD_NUMBER: begin
				case ($urandom_range(0, 2))
					0: push_text("-x");
					1: push_text("1.}");
					default: push_text("1e,");
				endcase
			end
			FIN_BAD_WORD: begin
				if ($urandom_range(0, 1))
					push_text("falsex");
				else
					push_text("nul,");
			end
			FIN_EARLY: begin
				case ($urandom_range(0, 2))
					0: ;
					1: push_text("\"ab");
					default: emit_number();
				endcase
				push_beat(OP_END, 8'($urandom_range(0, 255)));
			end
			default: repeat (MAX_DEPTH) push_byte(CH_LBRACK);
		endcase

		// everything after the document must be ignored
		repeat (NOISE_BEATS) push_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		wait (bytes_sent == byte_feed.size() && awaited_tokens.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (field_mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	always @(posedge clk) begin
		tok_t want_tok;
		bit   quiet;
		if (arst_n) begin
			quiet = (bytes_sent >= QUIET_FROM && bytes_sent < QUIET_TO);

			if (in_valid && in_ready) begin
				want_tok = tokenize_byte(op, text_byte);
				if (byte_feed[bytes_sent].typed)
					want_tok = byte_feed[bytes_sent].want;
				awaited_tokens.insert(awaited_tokens.size(), want_tok);
				bytes_sent++;
			end

			if (out_valid && out_ready) begin
				if (awaited_tokens.size() == 0) begin
					$error("result beat with no expected result");
					field_mismatches++;
				end else begin
					want_tok = awaited_tokens.pop_front();
					compare_field("token_kind", 8'(want_tok.kind), 8'(token_kind));
					compare_field("char_out", want_tok.ch, char_out);
					compare_field("is_content", 8'(want_tok.content), 8'(is_content));
					compare_field("token_start", 8'(want_tok.start), 8'(token_start));
					compare_field("token_done", 8'(want_tok.done), 8'(token_done));
					compare_field("prior_done", 8'(want_tok.pdone), 8'(prior_done));
					compare_field("prior_kind", 8'(want_tok.pkind), 8'(prior_kind));
					compare_field("bool_value", 8'(want_tok.bval), 8'(bool_value));
					compare_field("is_key", 8'(want_tok.key), 8'(is_key));
					compare_field("nest_level", 8'(want_tok.nest), 8'(nest_level));
					compare_field("status", 8'(want_tok.status), 8'(status));
				end
			end

			// hold the beat until taken; otherwise offer the next one or idle
			if (!in_valid || in_ready) begin
				if (bytes_sent == PAUSE_AT && !pause_done && awaited_tokens.size() != 0) begin
					in_valid <= 1'b0;
				end else if (bytes_sent < byte_feed.size()
						&& (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
					in_valid <= 1'b1;
					op <= byte_feed[bytes_sent].op;
					text_byte <= byte_feed[bytes_sent].ch;
					if (bytes_sent == PAUSE_AT)
						pause_done = 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end

			out_ready <= quiet || $urandom_range(0, 99) >= IDLE_PCT;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/jtsc_pkg.sv
sv/jtsc_front.sv
sv/jtsc_back.sv
sv/json_token_stream_checker.sv
bench/json_token_stream_checker_tb.sv
